// ----- hw/rtl/fas_pkg.sv -----
package fas_pkg;

    // Configuration port
    localparam int CfgAddrW = 2;
    localparam int CfgDataW = 16;

    localparam logic [CfgAddrW-1:0] CFG_WRITE_LIMIT  = 2'd0;
    localparam logic [CfgAddrW-1:0] CFG_START_PAGE   = 2'd1;
    localparam logic [CfgAddrW-1:0] CFG_START_OFFSET = 2'd2;

    // Register reset values and limits
    localparam logic [7:0]  LIMIT_RESET  = 8'h20;
    localparam logic [7:0]  LIMIT_FLOOR  = 8'd8;
    localparam logic [15:0] START_PAGE_RESET   = 16'd0;
    localparam logic [7:0]  START_OFFSET_RESET = 8'd0;

    // Page size default; room in a page needs one bit more than an offset
    localparam int PAGE_BYTES_DEF = 256;
    localparam int RoomW          = 9;

    // Input item kinds
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_RESET  = 1'b1;

    // Stream widths
    localparam int InDataW  = 8;
    localparam int OutDataW = 64;

    // Controller to datapath commands
    typedef struct packed {
        logic take;   // input item accepted this cycle
        logic step;   // advance the split by one chunk or one page skip
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic single;     // pending input item gives exactly one result at once
        logic room_zero;  // pointer sits past the page end: next step is a skip
        logic last;       // next chunk finishes the append
    } t_stat;

endpackage

// ----- hw/rtl/fas_ctrl.sv -----
module fas_ctrl
    import fas_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_out_ready,
    output logic  o_out_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;
    logic load;

    // Output slot frees up when empty or being taken this cycle
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        n_state    = r_state;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = out_free;
                o_cmd.take = i_in_valid && out_free;
                if (o_cmd.take && !i_stat.single) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                // A page skip needs no output slot
                o_cmd.step = i_stat.room_zero || out_free;
                if (o_cmd.step && !i_stat.room_zero && i_stat.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Track the output register occupancy
    assign load = (o_cmd.take && i_stat.single) || (o_cmd.step && !i_stat.room_zero);

    always_comb begin
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- hw/rtl/fas_dp.sv -----
module fas_dp
    import fas_pkg::*;
#(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgAddrW-1:0] i_cfg_addr,
    input  logic [CfgDataW-1:0] i_cfg_wdata,
    input  logic                i_op,
    input  logic [7:0]          i_len,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    output logic [OutDataW-1:0] o_data,
    output logic                o_last
);

    localparam logic [RoomW-1:0] PageSize = RoomW'(PAGE_BYTES);

    // Configuration registers
    logic [7:0]  r_write_limit;
    logic [15:0] r_start_page;
    logic [7:0]  r_start_offset;

    // Pointer and split counters
    logic [15:0] r_page, n_page;
    logic [7:0]  r_off, n_off;
    logic [7:0]  r_left, n_left;
    logic [7:0]  r_pos, n_pos;

    // Output register
    logic [15:0] r_o_cpage;
    logic [7:0]  r_o_coff;
    logic [7:0]  r_o_clen;
    logic [7:0]  r_o_idx;
    logic        r_o_last;
    logic [15:0] r_o_ppage;
    logic [7:0]  r_o_poff;

    logic [7:0]       limit;
    logic [RoomW-1:0] off_ext;
    logic [RoomW-1:0] left_ext;
    logic [RoomW-1:0] room;
    logic [RoomW-1:0] seg;
    logic [7:0]       clen;
    logic             past_end;
    logic             adv;
    logic             seg_end;
    logic             single;
    logic             chunk_load;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_limit  <= LIMIT_RESET;
            r_start_page   <= START_PAGE_RESET;
            r_start_offset <= START_OFFSET_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_WRITE_LIMIT:  r_write_limit  <= i_cfg_wdata[7:0];
                CFG_START_PAGE:   r_start_page   <= i_cfg_wdata;
                CFG_START_OFFSET: r_start_offset <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Compute the next chunk from the current pointer
    assign limit    = (r_write_limit < LIMIT_FLOOR) ? LIMIT_FLOOR : r_write_limit;
    assign off_ext  = {1'b0, r_off};
    assign left_ext = {1'b0, r_left};
    assign past_end = off_ext >= PageSize;
    assign room     = past_end ? '0 : PageSize - off_ext;
    assign adv      = left_ext >= room;
    assign seg      = adv ? room : left_ext;
    assign seg_end  = seg <= {1'b0, limit};
    assign clen     = seg_end ? seg[7:0] : limit;

    assign single     = (i_op == OP_RESET) || (i_len == 8'd0);
    assign chunk_load = i_cmd.step && !past_end;

    assign o_stat.single    = single;
    assign o_stat.room_zero = past_end;
    assign o_stat.last      = r_left == clen;

    // Update pointer and counters
    always_comb begin
        n_page = r_page;
        n_off  = r_off;
        n_left = r_left;
        n_pos  = r_pos;
        if (i_cmd.take) begin
            if (i_op == OP_RESET) begin
                n_page = r_start_page;
                n_off  = r_start_offset;
                n_left = '0;
                n_pos  = '0;
            end else begin
                n_left = i_len;
                n_pos  = '0;
                // Empty append still leaves a page it has overrun
                if (i_len == 8'd0 && past_end) begin
                    n_page = r_page + 16'd1;
                    n_off  = '0;
                end
            end
        end else if (i_cmd.step) begin
            if (past_end) begin
                n_page = r_page + 16'd1;
                n_off  = '0;
            end else begin
                n_left = r_left - clen;
                n_pos  = r_pos + clen;
                if (seg_end && adv) begin
                    n_page = r_page + 16'd1;
                    n_off  = '0;
                end else begin
                    n_off = r_off + clen;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page <= START_PAGE_RESET;
            r_off  <= START_OFFSET_RESET;
            r_left <= '0;
            r_pos  <= '0;
        end else begin
            r_page <= n_page;
            r_off  <= n_off;
            r_left <= n_left;
            r_pos  <= n_pos;
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && single) begin
            r_o_cpage <= (i_op == OP_RESET) ? r_start_page : r_page;
            r_o_coff  <= (i_op == OP_RESET) ? r_start_offset : r_off;
            r_o_clen  <= '0;
            r_o_idx   <= '0;
            r_o_last  <= 1'b1;
            r_o_ppage <= n_page;
            r_o_poff  <= n_off;
        end else if (chunk_load) begin
            r_o_cpage <= r_page;
            r_o_coff  <= r_off;
            r_o_clen  <= clen;
            r_o_idx   <= r_pos;
            r_o_last  <= r_left == clen;
            r_o_ppage <= n_page;
            r_o_poff  <= n_off;
        end
    end

    assign o_data = {r_o_poff, r_o_ppage, r_o_idx, r_o_clen, r_o_coff, r_o_cpage};
    assign o_last = r_o_last;

endmodule

// ----- hw/rtl/flash_append_write_splitter.sv -----
// Append splitter for a log kept in page-programmed flash.
// Slave stream: one item per request; tuser is the op (append or pointer
// reset), tdata the append length. Master stream: one item per program chunk,
// tlast on the final chunk of a request. A reset op or an empty append gives
// one zero-length item.
// Config port: write write_limit, start_page or start_offset by index while
// the block is idle; a write takes effect on the next edge.
// Timing: a single-result request shows its item in the cycle after acceptance.
// An append first loads its counters and enters the run state; each step then
// loads one chunk into the output register, one chunk per cycle while the
// receiver takes them; a pointer past the page end costs a page skip step.
// A request holds the block until its last chunk is loaded; only then is a new request taken.
// Reset: synchronous, clears the pointer to page 0 offset 0, write_limit to
// 32, start registers to 0, and empties the output register.
// Stall: the block holds its output item and pauses the split (page skips
// go on) until the receiver takes it; a new request is taken only when
// the output register is empty or its item leaves in the same cycle.
module flash_append_write_splitter
    import fas_pkg::*;
#(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration
    input  logic                i_cfg_we,
    input  logic [CfgAddrW-1:0] i_cfg_addr,
    input  logic [CfgDataW-1:0] i_cfg_wdata,
    // Request stream
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [InDataW-1:0]  i_s_axis_tdata,   // [7:0] append_length
    input  logic                i_s_axis_tuser,   // [0] op
    // Chunk stream
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // [15:0] chunk_page, [23:16] chunk_offset, [31:24] chunk_length,
    // [39:32] data_index, [55:40] pointer_page, [63:56] pointer_offset
    output logic [OutDataW-1:0] o_m_axis_tdata,
    output logic                o_m_axis_tlast    // last_chunk
);

    t_cmd  cmd;
    t_stat stat;

    fas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    fas_dp #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (i_s_axis_tuser),
        .i_len       (i_s_axis_tdata[7:0]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_data      (o_m_axis_tdata),
        .o_last      (o_m_axis_tlast)
    );

    // Request is taken only when the output slot can take its first result
    a_ready_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("request taken while output slot is stalled");

    // Reset op gives its single item on the next cycle
    a_reset_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == OP_RESET)
        |=> (o_m_axis_tvalid && o_m_axis_tlast))
        else $error("reset op did not give one final item");

    // Zero-length items always close their request
    a_zero_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[31:24] == 8'd0) |-> o_m_axis_tlast)
        else $error("zero-length item without last mark");

endmodule

// ----- sim/flash_append_write_splitter_tb.sv -----
`timescale 1ns / 100ps

module flash_append_write_splitter_tb;
    import fas_pkg::*;

    localparam int PAGE        = PAGE_BYTES_DEF;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic       op;
        logic [7:0] len;
    } t_request;

    typedef struct packed {
        logic [15:0] cpage;
        logic [7:0]  coff;
        logic [7:0]  clen;
        logic [7:0]  didx;
        logic        last;
        logic [15:0] ppage;
        logic [7:0]  poff;
    } t_chunk;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CfgAddrW-1:0] i_cfg_addr = '0;
    logic [CfgDataW-1:0] i_cfg_wdata = '0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [InDataW-1:0]  i_s_axis_tdata = '0;
    logic                i_s_axis_tuser = 1'b0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [OutDataW-1:0] o_m_axis_tdata;
    logic                o_m_axis_tlast;

    // Register copies and append pointer as the block should hold them
    logic [7:0]  cfg_limit = LIMIT_RESET;
    logic [15:0] cfg_start_page = START_PAGE_RESET;
    logic [7:0]  cfg_start_off = START_OFFSET_RESET;
    logic [15:0] ptr_page = START_PAGE_RESET;
    logic [7:0]  ptr_off = START_OFFSET_RESET;

    t_request pending_reqs[$];
    t_chunk   chunks_due[$];
    t_request next_req;

    int   requests_queued = 0;
    int   requests_in = 0;
    int   fail_count = 0;
    logic req_taken = 1'b0;
    logic idling = 1'b1;
    int   send_gap = 0;
    int   stall_left = 0;
    int   rx_hold = 0;
    logic hold_done = 1'b0;

    flash_append_write_splitter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Cut one request into the chunks it must produce and advance the pointer
    task automatic plan_request(input logic op, input logic [7:0] len);
        int unsigned lim, left, room, seg, clen, pos;
        logic        adv;
        t_chunk      c;
        lim = 32'((cfg_limit < LIMIT_FLOOR) ? LIMIT_FLOOR : cfg_limit);
        c = '0;
        c.last = 1'b1;
        if (op == OP_RESET) begin
            ptr_page = cfg_start_page;
            ptr_off  = cfg_start_off;
            c.cpage = ptr_page;
            c.coff  = ptr_off;
            c.ppage = ptr_page;
            c.poff  = ptr_off;
            chunks_due.push_back(c);
        end else if (len == 8'd0) begin
            c.cpage = ptr_page;
            c.coff  = ptr_off;
            // pointer past the page end moves on to the next page
            if (int'(ptr_off) >= PAGE) begin
                ptr_page = ptr_page + 16'd1;
                ptr_off  = '0;
            end
            c.ppage = ptr_page;
            c.poff  = ptr_off;
            chunks_due.push_back(c);
        end else begin
            left = 32'(len);
            pos  = 0;
            while (left > 0) begin
                room = (int'(ptr_off) < PAGE) ? PAGE - ptr_off : 0;
                adv  = (left >= room);
                seg  = adv ? room : left;
                while (seg > 0) begin
                    clen = (seg < lim) ? seg : lim;
                    c.cpage = ptr_page;
                    c.coff  = ptr_off;
                    c.clen  = 8'(clen);
                    c.didx  = 8'(pos);
                    seg  = seg - clen;
                    left = left - clen;
                    pos  = pos + clen;
                    ptr_off = 8'(ptr_off + clen);
                    // chunk filling the page leaves the pointer on the next page
                    if (seg == 0 && adv) begin
                        ptr_page = ptr_page + 16'd1;
                        ptr_off  = '0;
                    end
                    c.last  = (left == 0);
                    c.ppage = ptr_page;
                    c.poff  = ptr_off;
                    chunks_due.push_back(c);
                end
                if (adv && room == 0) begin
                    ptr_page = ptr_page + 16'd1;
                    ptr_off  = '0;
                end
            end
        end
    endtask

    task automatic report_bad(input string what, input t_chunk want, input t_chunk got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t %s: exp pg=%h off=%h len=%h idx=%h last=%b ptr=%h/%h", $time,
                     what, want.cpage, want.coff, want.clen, want.didx, want.last,
                     want.ppage, want.poff);
            $display("%0t %s: got pg=%h off=%h len=%h idx=%h last=%b ptr=%h/%h", $time,
                     what, got.cpage, got.coff, got.clen, got.didx, got.last,
                     got.ppage, got.poff);
        end
    endtask

    // Predict accepted requests, then check the chunk taken at this edge
    always @(posedge i_clk) begin : chunk_check
        t_chunk got;
        t_chunk want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= i_s_axis_tvalid && o_s_axis_tready;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                plan_request(i_s_axis_tuser, i_s_axis_tdata);
                requests_in <= requests_in + 1;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.cpage = o_m_axis_tdata[15:0];
                got.coff  = o_m_axis_tdata[23:16];
                got.clen  = o_m_axis_tdata[31:24];
                got.didx  = o_m_axis_tdata[39:32];
                got.last  = o_m_axis_tlast;
                got.ppage = o_m_axis_tdata[55:40];
                got.poff  = o_m_axis_tdata[63:56];
                if (chunks_due.size() == 0) begin
                    report_bad("unexpected chunk", '0, got);
                end else begin
                    want = chunks_due.pop_front();
                    if (got.cpage !== want.cpage || got.coff !== want.coff ||
                        got.clen !== want.clen || got.didx !== want.didx ||
                        got.last !== want.last || got.ppage !== want.ppage ||
                        got.poff !== want.poff)
                        report_bad("chunk mismatch", want, got);
                end
            end
        end
    end

    // Present requests from the pending queue, with random gaps while idling is set
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || req_taken) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (pending_reqs.size() != 0 && idling && $urandom_range(0, 4) == 0) begin
                send_gap <= $urandom_range(0, 10);
                i_s_axis_tvalid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                next_req = pending_reqs.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= next_req.len;
                i_s_axis_tuser  <= next_req.op;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Stall the chunk stream in random bursts while idling is set, and during the long hold
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (rx_hold != 0) begin
            i_m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (idling && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 10);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Hold off the receiver once for a long stretch so the block backs up
    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else if (!hold_done && requests_in == HOLD_AT) begin
            rx_hold   <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    task automatic send(input logic op, input logic [7:0] len);
        t_request r;
        r.op  = op;
        r.len = len;
        pending_reqs.push_back(r);
        requests_queued++;
    endtask

    task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        case (addr)
            CFG_WRITE_LIMIT:  cfg_limit = value[7:0];
            CFG_START_PAGE:   cfg_start_page = value;
            CFG_START_OFFSET: cfg_start_off = value[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every request is taken and every chunk has come out
    task automatic drain();
        @(negedge i_clk);
        while (requests_in != requests_queued || chunks_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic random_requests(input int count);
        int pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send(OP_RESET, 8'($urandom_range(0, 255)));
            else if (pick < 16)
                send(OP_APPEND, 8'd0);
            else if (pick < 30)
                send(OP_APPEND, 8'($urandom_range(200, 255)));
            else if (pick < 45)
                send(OP_APPEND, 8'($urandom_range(0, 255)));
            else
                send(OP_APPEND, 8'($urandom_range(1, 64)));
        end
    endtask

    task automatic random_settings();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            write_reg(CFG_WRITE_LIMIT, 16'(LIMIT_FLOOR));
        else if (pick < 4)
            write_reg(CFG_WRITE_LIMIT, 16'd255);
        else if (pick < 5)
            write_reg(CFG_WRITE_LIMIT, 16'($urandom_range(0, 7)));
        else
            write_reg(CFG_WRITE_LIMIT, 16'($urandom_range(8, 255)));
        pick = $urandom_range(0, 3);
        write_reg(CFG_START_PAGE, pick == 0 ? 16'hFFFF : pick == 1 ? 16'h0000 :
                  16'($urandom_range(0, 65535)));
        write_reg(CFG_START_OFFSET, 16'($urandom_range(0, 255)));
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: empty append, page-filling and page-crossing appends
        send(OP_APPEND, 8'd0);
        send(OP_APPEND, 8'd1);
        send(OP_APPEND, 8'd255);
        send(OP_APPEND, 8'd31);
        send(OP_APPEND, 8'd32);
        send(OP_APPEND, 8'd33);
        send(OP_RESET, 8'd0);
        send(OP_APPEND, 8'd200);
        send(OP_APPEND, 8'd56);
        send(OP_APPEND, 8'd100);
        drain();

        // Floor limit, last page and last offset: wrap of the page number
        write_reg(CFG_WRITE_LIMIT, 16'(LIMIT_FLOOR));
        write_reg(CFG_START_PAGE, 16'hFFFF);
        write_reg(CFG_START_OFFSET, 16'd255);
        send(OP_RESET, 8'hFF);
        send(OP_APPEND, 8'd0);
        send(OP_APPEND, 8'd1);
        send(OP_RESET, 8'd0);
        send(OP_APPEND, 8'd255);
        send(OP_APPEND, 8'd7);
        drain();

        // Limit below the floor acts as the floor
        write_reg(CFG_WRITE_LIMIT, 16'd0);
        write_reg(CFG_START_OFFSET, 16'd0);
        send(OP_RESET, 8'd0);
        send(OP_APPEND, 8'd20);
        send(OP_APPEND, 8'd255);
        drain();
        write_reg(CFG_WRITE_LIMIT, 16'd5);
        send(OP_APPEND, 8'd17);
        drain();

        // Largest limit from the middle of a page
        write_reg(CFG_WRITE_LIMIT, 16'd255);
        write_reg(CFG_START_PAGE, 16'h1234);
        write_reg(CFG_START_OFFSET, 16'd128);
        send(OP_RESET, 8'd0);
        send(OP_APPEND, 8'd255);
        send(OP_APPEND, 8'd255);
        send(OP_APPEND, 8'd0);
        drain();

        // Random phases; the last one runs without idling
        for (int phase = 0; phase < 4; phase++) begin
            random_settings();
            if (phase == 3)
                idling = 1'b0;
            random_requests(84);
            drain();
        end
        repeat (20) @(negedge i_clk);

        if (fail_count == 0 && chunks_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
